[rtl/core/mpe_pkg.sv]
`default_nettype none

package mpe_pkg;

  // Fixed field widths of the item and result words
  localparam int OP_W       = 2;
  localparam int INDEX_W    = 4;
  localparam int IN_VALUE_W = 16;
  localparam int LEN_W      = 5;
  localparam int OUT_W      = 36;

  // Reset value of the inner length register
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Operation codes carried by an input word
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[rtl/core/matrix_product_engine.sv]
`default_nettype none
// Write of A or B: the next word is taken in the following cycle.
// Product read: L element pairs, one per cycle, L = inner_length clipped to MAX_DIM;
// the result follows once the pipe has drained and the output register is free,
// and is zero when the sum is empty or the entry lies outside the matrix.
// Reset clears the sequencer, output valid and sets inner_length to 16; the
// A and B memories are not cleared and hold garbage until written.
module matrix_product_engine #(
  parameter int MAX_DIM       = 16,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mpe_pkg::LEN_W-1:0]            cfg_inner_length,
  // input words
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [mpe_pkg::OP_W-1:0]             in_operation,
  input  wire logic [mpe_pkg::INDEX_W-1:0]          in_row_index,
  input  wire logic [mpe_pkg::INDEX_W-1:0]          in_column_index,
  input  wire logic signed [mpe_pkg::IN_VALUE_W-1:0] in_element_value,
  // result words
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mpe_pkg::OUT_W-1:0]          out_product_value
);

  import mpe_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int EW    = ELEMENT_WIDTH;
  localparam int PW    = 2 * EW;
  localparam int SUM_W = ((PW > OUT_W) ? PW : OUT_W) + 1;

  localparam logic [7:0]    DIM8     = 8'(MAX_DIM);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_DIM);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  // registers
  state_t                    state_r, state_nxt;
  logic [LEN_W-1:0]          inner_len_r;
  logic [CNT_W-1:0]          issue_cnt_r, issue_cnt_nxt;
  logic [AW-1:0]             a_addr_r, a_addr_nxt;
  logic [AW-1:0]             b_addr_r, b_addr_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic                      mul_v_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [OUT_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]   out_value_r, out_value_nxt;

  // combinational
  logic                      in_accept;
  logic                      row_ok, col_ok;
  logic [7:0]                len8, len_clip;
  logic [AW-1:0]             row_base, wr_addr;
  logic signed [EW-1:0]      elem;
  logic                      wr_a, wr_b;
  logic signed [EW-1:0]      a_rd, b_rd;
  logic signed [SUM_W-1:0]   sum;
  logic signed [OUT_W-1:0]   sum_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_product_value = out_value_r;

  // decode the incoming word
  assign row_ok   = ({4'b0, in_row_index} < DIM8);
  assign col_ok   = ({4'b0, in_column_index} < DIM8);
  assign len8     = {3'b0, inner_len_r};
  assign len_clip = (len8 > DIM8) ? DIM8 : len8;
  assign row_base = AW'(AW'(in_row_index) * ROW_STEP);
  assign wr_addr  = AW'(row_base + AW'(in_column_index));
  assign elem     = EW'(in_element_value);
  assign wr_a     = in_accept && row_ok && col_ok && (in_operation == OP_WRITE_A);
  assign wr_b     = in_accept && row_ok && col_ok && (in_operation == OP_WRITE_B);

  mpe_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (wr_addr),
    .wr_data (elem),
    .rd_addr (a_addr_r),
    .rd_data (a_rd)
  );

  mpe_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (wr_addr),
    .wr_data (elem),
    .rd_addr (b_addr_r),
    .rd_data (b_rd)
  );

  // accumulate with saturation to the result range
  assign sum = SUM_W'(acc_r) + SUM_W'(prod_r);
  always_comb begin
    if (sum > SAT_MAX) begin
      sum_sat = OUT_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      sum_sat = OUT_W'(SAT_MIN);
    end else begin
      sum_sat = OUT_W'(sum);
    end
  end

  // sequencer: next state, addresses and result
  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue_cnt_r;
    a_addr_nxt    = a_addr_r;
    b_addr_nxt    = b_addr_r;
    rd_v_nxt      = 1'b0;
    acc_nxt       = mul_v_r ? sum_sat : acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_operation == OP_READ)) begin
          state_nxt  = ST_RUN;
          acc_nxt    = '0;
          a_addr_nxt = row_base;
          b_addr_nxt = AW'(in_column_index);
          if (row_ok && col_ok) begin
            issue_cnt_nxt = CNT_W'(len_clip);
          end else begin
            issue_cnt_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        // issue one element pair per cycle, then drain the pipe
        if (issue_cnt_r != '0) begin
          rd_v_nxt      = 1'b1;
          issue_cnt_nxt = issue_cnt_r - CNT_W'(1);
          a_addr_nxt    = a_addr_r + AW'(1);
          b_addr_nxt    = b_addr_r + ROW_STEP;
        end else if (!rd_v_r && !mul_v_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inner_len_r <= LEN_RESET;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      issue_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        inner_len_r <= cfg_inner_length;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_addr_r    <= a_addr_nxt;
    b_addr_r    <= b_addr_nxt;
    prod_r      <= a_rd * b_rd;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  // checks
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");

  a_mul_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r |-> $past(rd_v_r))
    else $error("multiply stage valid without a read");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_v_r && !mul_v_r))
    else $error("pipe busy while idle");

  a_drain_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && issue_cnt_r == '0 && !rd_v_r && !mul_v_r)
      |=> (state_r == ST_FIN))
    else $error("drained pipe did not finish");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (!wr_a && !wr_b))
    else $error("memory write during product read");

endmodule

`default_nettype wire

[rtl/core/mpe_ram.sv]
`default_nettype none

module mpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
